/* hdl/ouart_pkg.sv */
// ----------------------------------------------------------------------------
// ouart_pkg
// Request codes and frame constants of the oversampled 8N1 UART.
// ----------------------------------------------------------------------------
package ouart_pkg;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_READ    = 3'd2,
        REQ_DISABLE = 3'd3,
        REQ_ENABLE  = 3'd4
    } req_t;

    localparam logic [3:0] FRAME_BITS         = 4'd10;
    localparam logic [3:0] DATA_BITS          = 4'd8;
    localparam logic [1:0] TICKS_PER_BIT      = 2'd3;
    localparam logic [2:0] RX_TICKS_PER_BIT   = 3'd3;
    localparam logic [2:0] RX_FIRST_SAMPLE    = 3'd4;

    typedef struct packed {
        logic tx_line;
        logic rd_valid;
        logic pending;
        logic busy;
        logic dropped;
    } status_t;

endpackage

/* hdl/ouart_ram.sv */
// ----------------------------------------------------------------------------
// ouart_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ouart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/oversampled_uart_8n1.sv */
// ----------------------------------------------------------------------------
// oversampled_uart_8n1
// 8N1 UART stepped by requests: ticks at three times the baud rate, byte
// writes into a transmit queue, byte reads from a receive ring, gating.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request per transfer:
// req_type, rx_line (used on a tick) and tx_byte (used on a write).
// Output channel (out_valid/out_ready) returns exactly one status item per
// request: tx_line, rx_data, rx_data_valid, rx_pending, tx_busy, tx_dropped.
// A request is accepted every cycle while the output side keeps up. The state
// update and the registered read of the receive ring RAM share the first
// stage of its status item; the output register is the second.
// The transmit queue and the receive ring each sit in one RAM with a
// registered read; the next queued byte is fetched when a frame ends and
// folded into the frame register in the following cycle, before it is shifted.
// When the output side stalls, the two stages fill and in_ready drops;
// nothing is lost or repeated. Reset empties the queue and ring pointers,
// enables ticks and sets the transmit level high; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module oversampled_uart_8n1 #(
    parameter int RX_RING_DEPTH  = 16,
    parameter int TX_QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    input  logic       rx_line,
    input  logic [7:0] tx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_line,
    output logic [7:0] rx_data,
    output logic       rx_data_valid,
    output logic       rx_pending,
    output logic       tx_busy,
    output logic       tx_dropped
);

    localparam int TXQ_AW = $clog2(TX_QUEUE_DEPTH);
    localparam int TXQ_PW = $clog2(2 * TX_QUEUE_DEPTH);
    localparam int RX_AW  = $clog2(RX_RING_DEPTH);

    localparam logic [TXQ_PW-1:0] TXQ_DEPTH = TXQ_PW'(TX_QUEUE_DEPTH);
    localparam logic [TXQ_PW-1:0] TXQ_LAST  = TXQ_PW'(2 * TX_QUEUE_DEPTH - 1);
    localparam logic [RX_AW-1:0]  RX_LAST   = RX_AW'(RX_RING_DEPTH - 1);

    logic              enabled_reg, enabled_next;
    logic              tx_level_reg, tx_level_next;
    logic              tx_active_reg, tx_active_next;
    logic [1:0]        tx_tick_reg, tx_tick_next;
    logic [3:0]        tx_bits_reg, tx_bits_next;
    logic [9:0]        tx_frame_reg, tx_frame_next;
    logic              tx_load_reg, tx_load_next;
    logic [TXQ_PW-1:0] txq_wr_reg, txq_wr_next;
    logic [TXQ_PW-1:0] txq_rd_reg, txq_rd_next;
    logic              rx_active_reg, rx_active_next;
    logic              rx_wait_reg, rx_wait_next;
    logic [2:0]        rx_tick_reg, rx_tick_next;
    logic [3:0]        rx_bits_reg, rx_bits_next;
    logic [7:0]        rx_shift_reg, rx_shift_next;
    logic [RX_AW-1:0]  rx_wr_reg, rx_wr_next;
    logic [RX_AW-1:0]  rx_rd_reg, rx_rd_next;

    logic                  s1_valid_reg;
    ouart_pkg::status_t    s1_reg, s1_next;
    logic                  out_valid_reg;
    ouart_pkg::status_t    out_reg;
    logic [7:0]            out_data_reg;

    logic              accept;
    logic              s1_adv;
    logic [9:0]        frame_cur;
    logic [TXQ_PW-1:0] txq_wr_full, txq_rd_full;
    logic [TXQ_AW-1:0] txq_wr_idx, txq_rd_idx;
    logic              txq_empty, txq_full;
    logic              txq_we, txq_re;
    logic [7:0]        txq_rdata;
    logic              rx_we, rx_re;
    logic [7:0]        rx_rdata;
    logic [2:0]        rx_bit_idx;
    logic [3:0]        rx_bit_off;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign frame_cur   = tx_load_reg ? {1'b1, txq_rdata, 1'b0} : tx_frame_reg;
    assign txq_wr_full = (txq_wr_reg >= TXQ_DEPTH) ? txq_wr_reg - TXQ_DEPTH : txq_wr_reg;
    assign txq_rd_full = (txq_rd_reg >= TXQ_DEPTH) ? txq_rd_reg - TXQ_DEPTH : txq_rd_reg;
    assign txq_wr_idx  = txq_wr_full[TXQ_AW-1:0];
    assign txq_rd_idx  = txq_rd_full[TXQ_AW-1:0];
    assign txq_empty   = txq_wr_reg == txq_rd_reg;
    assign txq_full    = !txq_empty && (txq_wr_idx == txq_rd_idx);
    assign rx_bit_off  = ouart_pkg::DATA_BITS - rx_bits_reg;
    assign rx_bit_idx  = rx_bit_off[2:0];

    always_comb
    begin
        enabled_next   = enabled_reg;
        tx_level_next  = tx_level_reg;
        tx_active_next = tx_active_reg;
        tx_tick_next   = tx_tick_reg;
        tx_bits_next   = tx_bits_reg;
        tx_frame_next  = frame_cur;
        tx_load_next   = 1'b0;
        txq_wr_next    = txq_wr_reg;
        txq_rd_next    = txq_rd_reg;
        rx_active_next = rx_active_reg;
        rx_wait_next   = rx_wait_reg;
        rx_tick_next   = rx_tick_reg;
        rx_bits_next   = rx_bits_reg;
        rx_shift_next  = rx_shift_reg;
        rx_wr_next     = rx_wr_reg;
        rx_rd_next     = rx_rd_reg;
        txq_we         = 1'b0;
        txq_re         = 1'b0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        s1_next        = '0;

        if (accept)
        begin
            case (ouart_pkg::req_t'(req_type))
                ouart_pkg::REQ_TICK:
                begin
                    if (enabled_reg)
                    begin
                        if (tx_active_reg)
                        begin
                            if (tx_tick_reg > 2'd1)
                            begin
                                tx_tick_next = tx_tick_reg - 2'd1;
                            end
                            else
                            begin
                                tx_level_next = frame_cur[0];
                                tx_frame_next = {1'b0, frame_cur[9:1]};
                                tx_tick_next  = ouart_pkg::TICKS_PER_BIT;
                                if (tx_bits_reg > 4'd1)
                                begin
                                    tx_bits_next = tx_bits_reg - 4'd1;
                                end
                                else
                                begin
                                    tx_bits_next   = 4'd0;
                                    tx_active_next = 1'b0;
                                    if (!txq_empty)
                                    begin
                                        txq_re         = 1'b1;
                                        tx_load_next   = 1'b1;
                                        txq_rd_next    = (txq_rd_reg == TXQ_LAST) ? '0
                                                         : txq_rd_reg + 1'b1;
                                        tx_tick_next   = ouart_pkg::TICKS_PER_BIT;
                                        tx_bits_next   = ouart_pkg::FRAME_BITS;
                                        tx_active_next = 1'b1;
                                    end
                                end
                            end
                        end

                        if (rx_wait_reg)
                        begin
                            if (rx_tick_reg > 3'd1)
                            begin
                                rx_tick_next = rx_tick_reg - 3'd1;
                            end
                            else
                            begin
                                rx_tick_next   = 3'd0;
                                rx_wait_next   = 1'b0;
                                rx_active_next = 1'b0;
                                if (rx_line)
                                begin
                                    rx_we      = 1'b1;
                                    rx_wr_next = (rx_wr_reg == RX_LAST) ? '0
                                                 : rx_wr_reg + 1'b1;
                                end
                            end
                        end
                        else if (!rx_active_reg)
                        begin
                            if (!rx_line)
                            begin
                                rx_active_next = 1'b1;
                                rx_shift_next  = 8'd0;
                                rx_tick_next   = ouart_pkg::RX_FIRST_SAMPLE;
                                rx_bits_next   = ouart_pkg::DATA_BITS;
                            end
                        end
                        else if (rx_tick_reg > 3'd1)
                        begin
                            rx_tick_next = rx_tick_reg - 3'd1;
                        end
                        else
                        begin
                            rx_tick_next = ouart_pkg::RX_TICKS_PER_BIT;
                            if (rx_line && (rx_bits_reg inside {[4'd1:4'd8]}))
                            begin
                                rx_shift_next[rx_bit_idx] = 1'b1;
                            end
                            if (rx_bits_reg > 4'd1)
                            begin
                                rx_bits_next = rx_bits_reg - 4'd1;
                            end
                            else
                            begin
                                rx_bits_next = 4'd0;
                                rx_wait_next = 1'b1;
                            end
                        end
                    end
                end
                ouart_pkg::REQ_WRITE:
                begin
                    if (tx_active_reg)
                    begin
                        if (txq_full)
                        begin
                            s1_next.dropped = 1'b1;
                        end
                        else
                        begin
                            txq_we      = 1'b1;
                            txq_wr_next = (txq_wr_reg == TXQ_LAST) ? '0 : txq_wr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        tx_tick_next   = ouart_pkg::TICKS_PER_BIT;
                        tx_bits_next   = ouart_pkg::FRAME_BITS;
                        tx_frame_next  = {1'b1, tx_byte, 1'b0};
                        tx_active_next = 1'b1;
                    end
                end
                ouart_pkg::REQ_READ:
                begin
                    if (rx_rd_reg != rx_wr_reg)
                    begin
                        rx_re            = 1'b1;
                        s1_next.rd_valid = 1'b1;
                        rx_rd_next       = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
                    end
                end
                ouart_pkg::REQ_DISABLE:
                begin
                    enabled_next   = 1'b0;
                    rx_wait_next   = 1'b0;
                    tx_active_next = 1'b0;
                    rx_active_next = 1'b0;
                end
                ouart_pkg::REQ_ENABLE:
                begin
                    enabled_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        s1_next.tx_line = tx_level_next;
        s1_next.pending = rx_rd_next != rx_wr_next;
        s1_next.busy    = tx_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            tx_level_reg  <= 1'b1;
            tx_active_reg <= 1'b0;
            tx_tick_reg   <= 2'd0;
            tx_bits_reg   <= 4'd0;
            tx_frame_reg  <= 10'd0;
            tx_load_reg   <= 1'b0;
            txq_wr_reg    <= '0;
            txq_rd_reg    <= '0;
            rx_active_reg <= 1'b0;
            rx_wait_reg   <= 1'b0;
            rx_tick_reg   <= 3'd0;
            rx_bits_reg   <= 4'd0;
            rx_shift_reg  <= 8'd0;
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            tx_level_reg  <= tx_level_next;
            tx_active_reg <= tx_active_next;
            tx_tick_reg   <= tx_tick_next;
            tx_bits_reg   <= tx_bits_next;
            tx_frame_reg  <= tx_frame_next;
            tx_load_reg   <= tx_load_next;
            txq_wr_reg    <= txq_wr_next;
            txq_rd_reg    <= txq_rd_next;
            rx_active_reg <= rx_active_next;
            rx_wait_reg   <= rx_wait_next;
            rx_tick_reg   <= rx_tick_next;
            rx_bits_reg   <= rx_bits_next;
            rx_shift_reg  <= rx_shift_next;
            rx_wr_reg     <= rx_wr_next;
            rx_rd_reg     <= rx_rd_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_reg      <= s1_reg;
            out_data_reg <= s1_reg.rd_valid ? rx_rdata : 8'd0;
        end
    end

    ouart_ram #(
        .WIDTH (8),
        .DEPTH (TX_QUEUE_DEPTH)
    ) u_txq_ram (
        .clk   (clk),
        .we    (txq_we),
        .waddr (txq_wr_idx),
        .wdata (tx_byte),
        .re    (txq_re),
        .raddr (txq_rd_idx),
        .rdata (txq_rdata)
    );

    ouart_ram #(
        .WIDTH (8),
        .DEPTH (RX_RING_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (rx_shift_reg),
        .re    (rx_re),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign tx_line       = out_reg.tx_line;
    assign rx_data       = out_data_reg;
    assign rx_data_valid = out_reg.rd_valid;
    assign rx_pending    = out_reg.pending;
    assign tx_busy       = out_reg.busy;
    assign tx_dropped    = out_reg.dropped;

endmodule
